// ===== hdl/tsi_pkg.sv =====
`default_nettype none
package tsi_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int TIME_W = 40;
  localparam int VAL_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int DEN_W = TIME_W + 1;
  localparam int MAG_W = VAL_W + 1;
  localparam int PROD_W = DEN_W + MAG_W;
  localparam int REM_W = DEN_W + 1;
  localparam int STEP_W = $clog2(PROD_W + 1);

  typedef logic signed [TIME_W-1:0] time_t;
  typedef logic signed [VAL_W-1:0] value_t;

  typedef struct packed {
    time_t  tp;
    value_t val;
  } entry_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_SEEK  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_BACKWARD = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_LINEAR   = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_EXACT  = 2'd0,
    ST_HELD   = 2'd1,
    ST_BEFORE = 2'd2,
    ST_PAST   = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_SK_RD, S_SK_CMP, S_Q_RD, S_Q_CMP,
    S_PV_RD, S_PV_CMP, S_LERP, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    L_IDLE, L_MUL, L_DIV
  } lstate_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lerp_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quot;
  } lerp_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/tsi_if.sv =====
`default_nettype none
interface tsi_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [tsi_pkg::ADDR_W-1:0]     entry_index;
  logic signed [tsi_pkg::TIME_W-1:0] time_point;
  logic signed [tsi_pkg::VAL_W-1:0]  entry_value;
  modport source (output valid, kind, entry_index, time_point, entry_value, input ready);
  modport sink (input valid, kind, entry_index, time_point, entry_value, output ready);
endinterface

interface tsi_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tsi_pkg::VAL_W-1:0] value;
  logic [1:0]                       status;
  logic                             active;
  modport source (output valid, value, status, active, input ready);
  modport sink (input valid, value, status, active, output ready);
endinterface
`default_nettype wire

// ===== hdl/tsi_table.sv =====
`default_nettype none
module tsi_table (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [tsi_pkg::ADDR_W-1:0] waddr,
  input  wire tsi_pkg::entry_t            wdata,
  input  wire logic [tsi_pkg::ADDR_W-1:0] raddr,
  output tsi_pkg::entry_t                 rdata
);
  import tsi_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hdl/tsi_lerp.sv =====
`default_nettype none
module tsi_lerp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tsi_pkg::lerp_req_t req,
  output tsi_pkg::lerp_rsp_t      rsp
);
  import tsi_pkg::*;

  lstate_t             st_r, st_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [PROD_W-1:0]   mcand_r, mcand_nxt;
  logic [DEN_W-1:0]    mplier_r, mplier_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [MAG_W-1:0]    quot_r, quot_nxt;
  logic                done_r, done_nxt;
  logic [REM_W-1:0]    trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quot_r   <= quot_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    quot_nxt   = quot_r;
    done_nxt   = 1'b0;
    trial      = {rem_r[REM_W-2:0], prod_r[PROD_W-1]};
    unique case (st_r)
      L_IDLE: begin
        if (req.start) begin
          prod_nxt   = '0;
          mcand_nxt  = PROD_W'(req.mag);
          mplier_nxt = req.num;
          den_nxt    = req.den;
          cnt_nxt    = STEP_W'(DEN_W);
          st_nxt     = L_MUL;
        end
      end
      L_MUL: begin
        if (mplier_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[DEN_W-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          rem_nxt  = '0;
          quot_nxt = '0;
          cnt_nxt  = STEP_W'(PROD_W);
          st_nxt   = L_DIV;
        end
      end
      L_DIV: begin
        prod_nxt = {prod_r[PROD_W-2:0], 1'b0};
        if (trial >= REM_W'(den_r)) begin
          rem_nxt  = trial - REM_W'(den_r);
          quot_nxt = {quot_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt  = trial;
          quot_nxt = {quot_r[MAG_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          done_nxt = 1'b1;
          st_nxt   = L_IDLE;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule
`default_nettype wire

// ===== hdl/time_series_interpolator.sv =====
`default_nettype none
// channel   dir  payload                                     handshake
// in_ch     in   kind, entry_index, time_point, entry_value  valid/ready
// out_ch    out  value, status, active                       valid/ready
// cfg       in   cfg_we, cfg_index, cfg_wdata                write only
// Write request: stored on accept. Seek: accept, binary-search steps (read, compare), done.
// Query: accept, a read and compare per entry scanned, then done (also past the end);
// the entry before adds a read and compare, interpolation a multiply, divide and handoff.
// One request at a time; the next is taken while a result waits in the output register.
// Reset clears cursor, range flag, last value, count and output valid, sets linear mode; table contents are undefined.
module time_series_interpolator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tsi_in_if.sink                               in_ch,
  tsi_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [tsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tsi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tsi_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cursor_r, cursor_nxt;
  logic                in_range_r, in_range_nxt;
  value_t              last_r, last_nxt;
  mode_t               mode_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    len;
  logic [CNT_W-1:0]    l_r, l_nxt, r_r, r_nxt;
  logic [CNT_W:0]      lr_sum;
  logic [CNT_W-1:0]    mid;
  time_t               t_r, t_nxt, t1_r, t1_nxt;
  value_t              y1_r, y1_nxt, y0_r, y0_nxt;
  value_t              res_r, res_nxt;
  status_t             st_r, st_nxt;
  logic                neg_r, neg_nxt;
  logic                ov_r, ov_nxt;
  value_t              ov_val_r, ov_val_nxt;
  status_t             ov_st_r, ov_st_nxt;
  logic                ov_act_r, ov_act_nxt;
  logic                tbl_we;
  entry_t              tbl_wdata, tbl_rdata;
  logic [ADDR_W-1:0]   raddr;
  lerp_req_t           lreq;
  lerp_rsp_t           lrsp;
  logic                in_acc;
  logic signed [DEN_W-1:0] den_s, num_s;
  logic signed [MAG_W-1:0] dy;
  logic signed [MAG_W:0]   sum;

  assign len = (count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_r;
  assign lr_sum = {1'b0, l_r} + {1'b0, r_r};
  assign mid = lr_sum[CNT_W:1];
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign tbl_we = in_acc && (kind_t'(in_ch.kind) == KIND_WRITE);
  assign tbl_wdata.tp = in_ch.time_point;
  assign tbl_wdata.val = in_ch.entry_value;

  tsi_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_ch.entry_index),
    .wdata (tbl_wdata),
    .raddr (raddr),
    .rdata (tbl_rdata)
  );

  tsi_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lreq),
    .rsp   (lrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cursor_r   <= '0;
      in_range_r <= 1'b0;
      last_r     <= '0;
      mode_r     <= MODE_LINEAR;
      count_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cursor_r   <= cursor_nxt;
      in_range_r <= in_range_nxt;
      last_r     <= last_nxt;
      ov_r       <= ov_nxt;
      if (cfg_we && cfg_index == REG_MODE) begin
        mode_r <= mode_t'(cfg_wdata[1:0]);
      end
      if (cfg_we && cfg_index == REG_COUNT) begin
        count_r <= cfg_wdata[CNT_W-1:0];
      end
    end
    l_r      <= l_nxt;
    r_r      <= r_nxt;
    t_r      <= t_nxt;
    t1_r     <= t1_nxt;
    y1_r     <= y1_nxt;
    y0_r     <= y0_nxt;
    res_r    <= res_nxt;
    st_r     <= st_nxt;
    neg_r    <= neg_nxt;
    ov_val_r <= ov_val_nxt;
    ov_st_r  <= ov_st_nxt;
    ov_act_r <= ov_act_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cursor_nxt   = cursor_r;
    in_range_nxt = in_range_r;
    last_nxt     = last_r;
    l_nxt        = l_r;
    r_nxt        = r_r;
    t_nxt        = t_r;
    t1_nxt       = t1_r;
    y1_nxt       = y1_r;
    y0_nxt       = y0_r;
    res_nxt      = res_r;
    st_nxt       = st_r;
    neg_nxt      = neg_r;
    ov_nxt       = ov_r && !out_ch.ready;
    ov_val_nxt   = ov_val_r;
    ov_st_nxt    = ov_st_r;
    ov_act_nxt   = ov_act_r;
    raddr        = cursor_r[ADDR_W-1:0];
    lreq.start   = 1'b0;
    den_s        = DEN_W'(t1_r) - DEN_W'(tbl_rdata.tp);
    num_s        = DEN_W'(t_r) - DEN_W'(tbl_rdata.tp);
    dy           = MAG_W'(y1_r) - MAG_W'(tbl_rdata.val);
    lreq.den     = den_s;
    lreq.num     = num_s[DEN_W-1] ? '0 : ((num_s > den_s) ? den_s : num_s);
    lreq.mag     = dy[MAG_W-1] ? -dy : dy;
    sum          = neg_r ? ((VAL_W+2)'(y0_r) - (VAL_W+2)'(lrsp.quot))
                         : ((VAL_W+2)'(y0_r) + (VAL_W+2)'(lrsp.quot));
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          t_nxt = in_ch.time_point;
          unique case (kind_t'(in_ch.kind))
            KIND_SEEK: begin
              l_nxt     = '0;
              r_nxt     = len;
              state_nxt = S_SK_RD;
            end
            KIND_QUERY: state_nxt = S_Q_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SK_RD: begin
        raddr = mid[ADDR_W-1:0];
        if ({1'b0, r_r} > {1'b0, l_r} + 1'b1) begin
          state_nxt = S_SK_CMP;
        end else begin
          cursor_nxt   = l_r;
          in_range_nxt = l_r < len;
          state_nxt    = S_IDLE;
        end
      end
      S_SK_CMP: begin
        if (t_r < tbl_rdata.tp) begin
          r_nxt = mid;
        end else begin
          l_nxt = mid;
        end
        state_nxt = S_SK_RD;
      end
      S_Q_RD: begin
        if (cursor_r < len) begin
          state_nxt = S_Q_CMP;
        end else begin
          in_range_nxt = 1'b0;
          res_nxt      = last_r;
          st_nxt       = ST_PAST;
          state_nxt    = S_DONE;
        end
      end
      S_Q_CMP: begin
        t1_nxt = tbl_rdata.tp;
        y1_nxt = tbl_rdata.val;
        if (t_r > tbl_rdata.tp) begin
          cursor_nxt = cursor_r + 1'b1;
          state_nxt  = S_Q_RD;
        end else begin
          in_range_nxt = 1'b1;
          state_nxt    = S_DONE;
          if (t_r == tbl_rdata.tp) begin
            res_nxt = tbl_rdata.val;
            st_nxt  = ST_EXACT;
          end else if (mode_r == MODE_FORWARD) begin
            res_nxt = tbl_rdata.val;
            st_nxt  = ST_HELD;
          end else if (cursor_r == '0) begin
            res_nxt = '0;
            st_nxt  = ST_BEFORE;
          end else begin
            state_nxt = S_PV_RD;
          end
        end
      end
      S_PV_RD: begin
        raddr     = ADDR_W'(cursor_r - 1'b1);
        state_nxt = S_PV_CMP;
      end
      S_PV_CMP: begin
        y0_nxt = tbl_rdata.val;
        st_nxt = ST_HELD;
        if (mode_r == MODE_BACKWARD || t1_r <= tbl_rdata.tp) begin
          res_nxt   = tbl_rdata.val;
          state_nxt = S_DONE;
        end else begin
          neg_nxt    = dy[MAG_W-1];
          lreq.start = 1'b1;
          state_nxt  = S_LERP;
        end
      end
      S_LERP: begin
        if (lrsp.done) begin
          res_nxt   = sum[VAL_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          ov_val_nxt = res_r;
          ov_st_nxt  = st_r;
          ov_act_nxt = in_range_r;
          if (st_r != ST_PAST) begin
            last_nxt = res_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid  = ov_r;
  assign out_ch.value  = ov_val_r;
  assign out_ch.status = ov_st_r;
  assign out_ch.active = ov_act_r;

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_Q_CMP |-> cursor_r < len)
    else $error("scan read past entries in use");
  a_lerp_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    lrsp.done |-> state_r == S_LERP)
    else $error("interpolation result with no request waiting");
  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!ov_r || out_ch.ready) |=> ov_r && state_r == S_IDLE)
    else $error("finished query not moved to output");
endmodule
`default_nettype wire
